// ===== rtl/mfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor feedback frame decoder package
// Shared widths, reset values, register indexes and the structs that pass
// configuration and results between the sequencer and the top level.
// ----------------------------------------------------------------------------
package mfd_pkg;

	localparam int POS_CNT_W = 16;
	localparam int VT_CNT_W  = 12;
	localparam int LIM_W     = 23;
	localparam int MUL_W     = 32;
	localparam int IN_W      = 72;
	localparam int OUT_W     = 192;

	localparam logic [21:0] RAD2DEG_Q16 = 22'd3754936;

	localparam logic [LIM_W-1:0] POS_LIM_RST   = 23'd819200;
	localparam logic [LIM_W-1:0] VEL_LIM_RST   = 23'd1966080;
	localparam logic [LIM_W-1:0] TOR_LIM_RST   = 23'd655360;
	localparam logic [LIM_W-1:0] RED_RECIP_RST = 23'd65536;

	localparam logic [POS_CNT_W-1:0] POS_ZERO = 16'd32768;
	localparam logic [3:0] MIN_FRAME_LEN = 4'd8;

	typedef enum logic [1:0] {
		REG_POS_LIM   = 2'd0,
		REG_VEL_LIM   = 2'd1,
		REG_TOR_LIM   = 2'd2,
		REG_RED_RECIP = 2'd3
	} mfd_reg_t;

	typedef struct packed {
		logic [LIM_W-1:0] pos_lim;
		logic [LIM_W-1:0] vel_lim;
		logic [LIM_W-1:0] tor_lim;
		logic [LIM_W-1:0] red_recip;
	} mfd_cfg_t;

	typedef struct packed {
		logic [29:0] rotor_pos;
		logic [29:0] shaft_vel;
		logic [23:0] torque;
		logic [31:0] turns;
		logic [47:0] shaft_total;
	} mfd_res_t;

endpackage

// ===== rtl/mfd_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 32 by 32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module mfd_mul import mfd_pkg::*; (
	input  logic                 clk,
	input  logic [MUL_W-1:0]     a,
	input  logic [MUL_W-1:0]     b,
	output logic [2*MUL_W-1:0]   prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

// ===== rtl/mfd_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decode sequencer
// Steps one frame through the shared multiplier: count mapping with a fold
// loop for the division by 2^n-1, turn tracking, and shaft scaling.
// ----------------------------------------------------------------------------
module mfd_seq import mfd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [POS_CNT_W-1:0] pos_cnt,
	input  logic [VT_CNT_W-1:0]  vel_cnt,
	input  logic [VT_CNT_W-1:0]  tor_cnt,
	input  mfd_cfg_t             cfg,
	input  logic                 out_free,
	output logic                 idle,
	output logic                 done,
	output mfd_res_t             res
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MUL0  = 4'd1;
	localparam logic [3:0] S_MUL1  = 4'd2;
	localparam logic [3:0] S_MUL2  = 4'd3;
	localparam logic [3:0] S_MUL3  = 4'd4;
	localparam logic [3:0] S_FOLD  = 4'd5;
	localparam logic [3:0] S_SPAN0 = 4'd6;
	localparam logic [3:0] S_SPAN1 = 4'd7;
	localparam logic [3:0] S_TURN0 = 4'd8;
	localparam logic [3:0] S_TURN1 = 4'd9;
	localparam logic [3:0] S_ABS   = 4'd10;
	localparam logic [3:0] S_TOT0  = 4'd11;
	localparam logic [3:0] S_TOT1  = 4'd12;
	localparam logic [3:0] S_TOT2  = 4'd13;
	localparam logic [3:0] S_DONE  = 4'd14;

	localparam logic [1:0] SEL_POS = 2'd0;
	localparam logic [1:0] SEL_VEL = 2'd1;
	localparam logic [1:0] SEL_TOR = 2'd2;

	// Returns the sign and magnitude of 2c - M for an n-bit count.
	function automatic logic [16:0] dev_of(input logic [15:0] c, input logic wide);
		logic [16:0] twoc;
		logic [16:0] m;
		twoc = {c, 1'b0};
		m    = wide ? 17'h0FFFF : 17'h00FFF;
		if (twoc < m) begin
			return {1'b1, 16'(m - twoc)};
		end else begin
			return {1'b0, 16'(twoc - m)};
		end
	endfunction

	logic [3:0]  state_q;
	logic [1:0]  sel_q;
	logic [15:0] last_q;
	logic [31:0] wrap_q;

	logic [VT_CNT_W-1:0] vel_c_q;
	logic [VT_CNT_W-1:0] tor_c_q;
	logic [15:0] dev_q;
	logic        neg_q;
	logic [38:0] p1_q;
	logic [54:0] acc_q;
	logic [45:0] y_q;
	logic [29:0] quo_q;
	logic [29:0] pos_q;
	logic [29:0] vel_q;
	logic [23:0] tor_q;
	logic [30:0] span_q;
	logic [29:0] svel_q;
	logic [63:0] total_q;
	logic [62:0] mag_q;
	logic [47:0] stot_q;

	logic [MUL_W-1:0]   mul_a;
	logic [MUL_W-1:0]   mul_b;
	logic [2*MUL_W-1:0] prod;

	logic              wide;
	logic [LIM_W-1:0]  lim_sel;
	logic [15:0]       m_val;
	logic [45:0]       f_hi;
	logic [15:0]       f_lo;
	logic [29:0]       f_quo;
	logic [29:0]       f_res;
	logic [45:0]       y_tor;
	logic [60:0]       mag_sum;
	logic [61:0]       mag_rnd;
	logic [45:0]       span_sum;
	logic              vel_neg;
	logic [29:0]       vel_mag;
	logic [52:0]       sv_sum;
	logic [36:0]       sv_cap;
	logic [29:0]       sv_sat;
	logic              wrap_neg;
	logic [31:0]       wrap_mag;
	logic [63:0]       pos_ext;
	logic [63:0]       tp_ext;
	logic [63:0]       total_neg;
	logic [85:0]       tot_sum;
	logic [69:0]       tot_rq;
	logic [69:0]       tot_cap;
	logic [47:0]       tot_sat;
	logic [16:0]       diff;
	logic [16:0]       vel_dev;
	logic [16:0]       tor_dev;
	logic [16:0]       pos_dev;

	mfd_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	always_comb begin
		wide  = (sel_q == SEL_POS);
		m_val = wide ? 16'hFFFF : 16'h0FFF;
		unique case (sel_q)
			SEL_POS: lim_sel = cfg.pos_lim;
			SEL_VEL: lim_sel = cfg.vel_lim;
			default: lim_sel = cfg.tor_lim;
		endcase

		f_hi  = wide ? (y_q >> 16) : (y_q >> 12);
		f_lo  = wide ? y_q[15:0] : {4'b0, y_q[11:0]};
		f_quo = quo_q + 30'(y_q == 46'(m_val));
		f_res = neg_q ? 30'(-f_quo) : f_quo;

		y_tor   = 46'(prod[38:0]) + 46'(m_val >> 1);
		mag_sum = 61'(acc_q) + {prod[28:0], 32'b0};
		mag_rnd = {1'b0, mag_sum} + (62'(m_val) << 15);

		span_sum = {1'b0, prod[44:0]} + 46'h4000;

		vel_neg = vel_q[29];
		vel_mag = vel_neg ? 30'(-vel_q) : vel_q;
		sv_sum  = prod[52:0] + 53'h8000;
		sv_cap  = (37'd1 << 29) - 37'(!vel_neg);
		sv_sat  = (sv_sum[52:16] > sv_cap) ? sv_cap[29:0] : sv_sum[45:16];

		wrap_neg = wrap_q[31];
		wrap_mag = wrap_neg ? 32'(-wrap_q) : wrap_q;
		pos_ext  = {{34{pos_q[29]}}, pos_q};
		tp_ext   = {1'b0, prod[62:0]};
		total_neg = -total_q;

		tot_sum = 86'(acc_q) + {prod[53:0], 32'b0} + 86'h8000;
		tot_rq  = tot_sum[85:16];
		tot_cap = (70'd1 << 47) - 70'(!neg_q);
		tot_sat = (tot_rq > tot_cap) ? tot_cap[47:0] : tot_rq[47:0];

		diff    = {1'b0, pos_cnt} - {1'b0, last_q};
		pos_dev = dev_of(pos_cnt, 1'b1);
		vel_dev = dev_of({4'b0, vel_c_q}, 1'b0);
		tor_dev = dev_of({4'b0, tor_c_q}, 1'b0);

		unique case (state_q)
			S_MUL0: begin
				mul_a = 32'(dev_q);
				mul_b = 32'(lim_sel);
			end
			S_MUL1: begin
				mul_a = prod[31:0];
				mul_b = 32'(RAD2DEG_Q16);
			end
			S_MUL2: begin
				mul_a = 32'(p1_q[38:32]);
				mul_b = 32'(RAD2DEG_Q16);
			end
			S_SPAN0: begin
				mul_a = 32'(cfg.pos_lim);
				mul_b = 32'(RAD2DEG_Q16);
			end
			S_SPAN1: begin
				mul_a = 32'(vel_mag);
				mul_b = 32'(cfg.red_recip);
			end
			S_TURN0: begin
				mul_a = wrap_mag;
				mul_b = 32'(span_q);
			end
			S_TOT0: begin
				mul_a = mag_q[31:0];
				mul_b = 32'(cfg.red_recip);
			end
			S_TOT1: begin
				mul_a = 32'(mag_q[62:32]);
				mul_b = 32'(cfg.red_recip);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= SEL_POS;
			last_q  <= POS_ZERO;
			wrap_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						sel_q  <= SEL_POS;
						last_q <= pos_cnt;
						if (!diff[16] && diff > 17'd32767) begin
							wrap_q <= wrap_q - 32'd1;
						end else if (diff[16] && diff <= 17'h18000) begin
							wrap_q <= wrap_q + 32'd1;
						end
						state_q <= S_MUL0;
					end
				end
				S_MUL0:  state_q <= S_MUL1;
				S_MUL1:  state_q <= (sel_q == SEL_TOR) ? S_FOLD : S_MUL2;
				S_MUL2:  state_q <= S_MUL3;
				S_MUL3:  state_q <= S_FOLD;
				S_FOLD: begin
					if (f_hi == '0) begin
						if (sel_q == SEL_TOR) begin
							state_q <= S_SPAN0;
						end else begin
							sel_q   <= (sel_q == SEL_POS) ? SEL_VEL : SEL_TOR;
							state_q <= S_MUL0;
						end
					end
				end
				S_SPAN0: state_q <= S_SPAN1;
				S_SPAN1: state_q <= S_TURN0;
				S_TURN0: state_q <= S_TURN1;
				S_TURN1: state_q <= S_ABS;
				S_ABS:   state_q <= S_TOT0;
				S_TOT0:  state_q <= S_TOT1;
				S_TOT1:  state_q <= S_TOT2;
				S_TOT2:  state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					vel_c_q <= vel_cnt;
					tor_c_q <= tor_cnt;
					neg_q   <= pos_dev[16];
					dev_q   <= pos_dev[15:0];
				end
			end
			S_MUL1: begin
				p1_q  <= prod[38:0];
				y_q   <= y_tor;
				quo_q <= '0;
			end
			S_MUL2: acc_q <= prod[54:0];
			S_MUL3: begin
				y_q   <= mag_rnd[61:16];
				quo_q <= '0;
			end
			S_FOLD: begin
				if (f_hi != '0) begin
					quo_q <= quo_q + f_hi[29:0];
					y_q   <= f_hi + 46'(f_lo);
				end else begin
					unique case (sel_q)
						SEL_POS: begin
							pos_q <= f_res;
							neg_q <= vel_dev[16];
							dev_q <= vel_dev[15:0];
						end
						SEL_VEL: begin
							vel_q <= f_res;
							neg_q <= tor_dev[16];
							dev_q <= tor_dev[15:0];
						end
						default: tor_q <= f_res[23:0];
					endcase
				end
			end
			S_SPAN1: span_q <= span_sum[45:15];
			S_TURN0: svel_q <= vel_neg ? 30'(-sv_sat) : sv_sat;
			S_TURN1: total_q <= wrap_neg ? (pos_ext - tp_ext) : (pos_ext + tp_ext);
			S_ABS: begin
				neg_q <= total_q[63];
				mag_q <= total_q[63] ? total_neg[62:0] : total_q[62:0];
			end
			S_TOT1: acc_q <= prod[54:0];
			S_TOT2: stot_q <= neg_q ? 48'(-tot_sat) : tot_sat;
			default: begin
			end
		endcase
	end

	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_DONE);

	assign res.rotor_pos   = pos_q;
	assign res.shaft_vel   = svel_q;
	assign res.torque      = tor_q;
	assign res.turns       = wrap_q;
	assign res.shaft_total = stot_q;

endmodule

// ===== rtl/motor_feedback_frame_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor feedback frame decoder
// Unpacks an 8-byte motor feedback frame, maps the raw counts onto the
// configured ranges in Q16.16 (degrees, or Nm for torque) and tracks multi-turn position.
//
// Channel  Dir  Handshake          Payload
// s_*      in   tvalid/tready      tdata: frame bytes 0..7, frame_length
// m_*      out  tvalid/tready      tdata: decoded feedback result
// cfg_*    in   cfg_we             cfg_addr selects the register, cfg_wdata
//
// A full frame is stepped through the shared 32x32 multiplier and the fold
// loop that divides by 2^n-1 before its result is offered.
// Frames shorter than eight bytes are accepted and dropped without a result.
// s_tready is high only while the sequencer is idle; a finished result waits
// in the sequencer if the output register is still held by m_tready low.
// Reset puts the turn counter at zero and the last position at mid-scale.
// ----------------------------------------------------------------------------
module motor_feedback_frame_decoder import mfd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_addr,
	input  logic [LIM_W-1:0] cfg_wdata,
	input  logic             s_tvalid,
	output logic             s_tready,
	// byte0 [7:0], byte1 .. byte7 [63:56], frame_length [67:64], zero pad
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// motor_id [3:0], motor_state [7:4], online [8], rotor_position_deg [38:9],
	// shaft_velocity_deg_s [68:39], torque_nm [92:69], temp_driver [100:93],
	// temp_rotor [108:101], turn_count [140:109],
	// shaft_total_position_deg [188:141], zero pad
	output logic [OUT_W-1:0] m_tdata
);

	mfd_cfg_t   cfg_q;
	mfd_res_t   res;
	logic       seq_idle;
	logic       seq_done;
	logic       out_free;
	logic       accept;
	logic       full_frame;
	logic       start;
	logic       m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;
	logic [3:0] id_q;
	logic [3:0] st_q;
	logic [7:0] tdrv_q;
	logic [7:0] trot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_lim   <= POS_LIM_RST;
			cfg_q.vel_lim   <= VEL_LIM_RST;
			cfg_q.tor_lim   <= TOR_LIM_RST;
			cfg_q.red_recip <= RED_RECIP_RST;
		end else if (cfg_we) begin
			unique case (mfd_reg_t'(cfg_addr))
				REG_POS_LIM:   cfg_q.pos_lim   <= cfg_wdata;
				REG_VEL_LIM:   cfg_q.vel_lim   <= cfg_wdata;
				REG_TOR_LIM:   cfg_q.tor_lim   <= cfg_wdata;
				REG_RED_RECIP: cfg_q.red_recip <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign s_tready   = seq_idle;
	assign accept     = s_tvalid & s_tready;
	assign full_frame = (s_tdata[67:64] >= MIN_FRAME_LEN);
	assign start      = accept & full_frame;
	assign out_free   = !m_tvalid_q || m_tready;

	always_ff @(posedge clk) begin
		if (start) begin
			id_q   <= s_tdata[3:0];
			st_q   <= s_tdata[7:4];
			tdrv_q <= s_tdata[55:48];
			trot_q <= s_tdata[63:56];
		end
	end

	mfd_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.pos_cnt  ({s_tdata[15:8], s_tdata[23:16]}),
		.vel_cnt  ({s_tdata[31:24], s_tdata[39:36]}),
		.tor_cnt  ({s_tdata[35:32], s_tdata[47:40]}),
		.cfg      (cfg_q),
		.out_free (out_free),
		.idle     (seq_idle),
		.done     (seq_done),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (seq_done && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_done && out_free) begin
			m_tdata_q <= {3'b0, res.shaft_total, res.turns, trot_q, tdrv_q, res.torque,
				res.shaft_vel, res.rotor_pos, st_q[0], st_q, id_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef ASSERT_OFF
	a_short_frame_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !full_frame) |=> s_tready)
		else $error("short frame started the sequencer");

	a_full_frame_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !s_tready)
		else $error("full frame did not occupy the sequencer");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_done && !out_free) |=> seq_done)
		else $error("finished result dropped while output was stalled");
`endif

endmodule

// ===== tb/motor_feedback_frame_decoder_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor feedback frame decoder result checker
// Follows the register writes and every frame beat taken by the decoder,
// decodes each full frame on its own copy of the limits and the turn
// tracking state, and compares every result beat field by field with the
// oldest decoded frame still outstanding.
// ----------------------------------------------------------------------------
module motor_feedback_frame_decoder_checker import mfd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_addr,
	input  logic [LIM_W-1:0] cfg_wdata,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [OUT_W-1:0] m_tdata,
	output int               errors,
	output int               pending
);

	typedef struct {
		logic [3:0]  id;
		logic [3:0]  state;
		logic        online;
		logic [29:0] rotor_pos;
		logic [29:0] shaft_vel;
		logic [23:0] torque;
		logic [7:0]  temp_drv;
		logic [7:0]  temp_rot;
		logic [31:0] turns;
		logic [47:0] shaft_total;
	} feedback_t;

	feedback_t feedback_due[$];
	int fail_count = 0;

	logic [LIM_W-1:0] pos_lim;
	logic [LIM_W-1:0] vel_lim;
	logic [LIM_W-1:0] tor_lim;
	logic [LIM_W-1:0] gear_recip;
	logic [15:0]      prev_pos;
	logic [31:0]      turn_total;

	assign errors  = fail_count;
	assign pending = feedback_due.size();

	task automatic report(input string msg);
		if (fail_count < 200) begin
			$display("%0t feedback check: %s", $time, msg);
		end
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want) begin
			report($sformatf("%s got %h want %h", name, got, want));
		end
	endtask

	// Maps an n-bit count onto [-lim, +lim] scaled by k, rounded half away
	// from zero.
	function automatic longint map_raw(input logic [63:0] cnt, input int nbits,
			input logic [63:0] lim, input logic [63:0] k);
		logic [63:0] full, twice, dev, mag, den, q;
		logic        neg;
		full  = (64'd1 << nbits) - 64'd1;
		twice = cnt * 64'd2;
		neg   = twice < full;
		dev   = neg ? full - twice : twice - full;
		mag   = dev * lim * k;
		den   = full << 16;
		q     = (mag + den / 64'd2) / den;
		return neg ? -$signed(q) : $signed(q);
	endfunction

	function automatic longint clamp_signed(input longint v, input int bits);
		longint upper;
		upper = (longint'(1) << (bits - 1)) - 1;
		if (v > upper) begin
			return upper;
		end
		if (v < -upper - 1) begin
			return -upper - 1;
		end
		return v;
	endfunction

	// Multiplies by a Q16.16 ratio with rounding and saturates to a signed
	// field of the given width.
	function automatic longint gear_scale(input longint v, input logic [63:0] r,
			input int bits);
		logic        neg;
		logic [63:0] mag, cap, q;
		neg = v < 0;
		mag = neg ? 64'd0 - v : v;
		cap = (64'd1 << (bits - 1)) - (neg ? 64'd0 : 64'd1);
		if (r == 64'd0) begin
			q = 64'd0;
		end else if ((mag >> 16) > ((64'd1 << 48) / r)) begin
			q = cap;
		end else begin
			q = (mag >> 16) * r + (((mag & 64'hFFFF) * r + 64'h8000) >> 16);
			if (q > cap) begin
				q = cap;
			end
		end
		return neg ? -$signed(q) : $signed(q);
	endfunction

	function automatic feedback_t decode_frame(input logic [IN_W-1:0] d);
		feedback_t   f;
		logic [15:0] pos_c;
		logic [11:0] vel_c, tor_c;
		logic [63:0] span;
		longint      rpos, rvel, trq, total, lim_v;
		int          step;
		pos_c = {d[15:8], d[23:16]};
		vel_c = {d[31:24], d[39:36]};
		tor_c = {d[35:32], d[47:40]};
		rpos  = map_raw(pos_c, POS_CNT_W, pos_lim, RAD2DEG_Q16);
		rvel  = map_raw(vel_c, VT_CNT_W, vel_lim, RAD2DEG_Q16);
		trq   = map_raw(tor_c, VT_CNT_W, tor_lim, 64'd65536);
		step = int'(pos_c) - int'(prev_pos);
		if (step > 32767) begin
			turn_total = turn_total - 32'd1;
		end else if (step < -32767) begin
			turn_total = turn_total + 32'd1;
		end
		prev_pos = pos_c;
		span  = (64'd2 * pos_lim * 64'(RAD2DEG_Q16) + 64'h8000) >> 16;
		total = longint'($signed(turn_total)) * longint'(span) + rpos;
		f.id       = d[3:0];
		f.state    = d[7:4];
		f.online   = d[4];
		f.temp_drv = d[55:48];
		f.temp_rot = d[63:56];
		f.turns    = turn_total;
		lim_v = clamp_signed(rpos, 30);
		f.rotor_pos = lim_v[29:0];
		lim_v = gear_scale(rvel, gear_recip, 30);
		f.shaft_vel = lim_v[29:0];
		lim_v = clamp_signed(trq, 24);
		f.torque = lim_v[23:0];
		lim_v = gear_scale(total, gear_recip, 48);
		f.shaft_total = lim_v[47:0];
		return f;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		feedback_t want;
		if (!arst_n) begin
			pos_lim    <= POS_LIM_RST;
			vel_lim    <= VEL_LIM_RST;
			tor_lim    <= TOR_LIM_RST;
			gear_recip <= RED_RECIP_RST;
			prev_pos   = POS_ZERO;
			turn_total = 32'd0;
			feedback_due.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (feedback_due.size() == 0) begin
					report("result beat with no full frame outstanding");
				end else begin
					want = feedback_due.pop_front();
					check_field("motor_id", m_tdata[3:0], want.id);
					check_field("motor_state", m_tdata[7:4], want.state);
					check_field("online", m_tdata[8], want.online);
					check_field("rotor_position_deg", m_tdata[38:9], want.rotor_pos);
					check_field("shaft_velocity_deg_s", m_tdata[68:39], want.shaft_vel);
					check_field("torque_nm", m_tdata[92:69], want.torque);
					check_field("temp_driver", m_tdata[100:93], want.temp_drv);
					check_field("temp_rotor", m_tdata[108:101], want.temp_rot);
					check_field("turn_count", m_tdata[140:109], want.turns);
					check_field("shaft_total_position_deg", m_tdata[188:141],
						want.shaft_total);
				end
			end
			if (cfg_we) begin
				case (cfg_addr)
					REG_POS_LIM: begin
						pos_lim <= cfg_wdata;
					end
					REG_VEL_LIM: begin
						vel_lim <= cfg_wdata;
					end
					REG_TOR_LIM: begin
						tor_lim <= cfg_wdata;
					end
					REG_RED_RECIP: begin
						gear_recip <= cfg_wdata;
					end
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready && s_tdata[67:64] >= MIN_FRAME_LEN) begin
				feedback_due.push_back(decode_frame(s_tdata));
			end
		end
	end

endmodule

// ===== tb/motor_feedback_frame_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor feedback frame decoder testbench
// Drives directed frames at the count extremes and the turn boundaries, then
// phases of random frames whose positions mostly walk across the wrap point,
// under limit settings from zero to full scale. Both stream sides idle at
// random; the result side also holds off long enough to stall the input.
// The checker beside the decoder predicts and compares every result beat.
// ----------------------------------------------------------------------------
module motor_feedback_frame_decoder_tb;
	import mfd_pkg::*;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [1:0]       cfg_addr;
	logic [LIM_W-1:0] cfg_wdata;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	int               errors;
	int               pending;

	bit          quiet;
	bit          hold_req;
	logic [15:0] walk_pos;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	motor_feedback_frame_decoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	motor_feedback_frame_decoder_checker u_feedback_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending)
	);

	function automatic int gap_len();
		int r;
		if (quiet) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] frame_bytes(input logic [3:0] id,
			input logic [3:0] st, input logic [15:0] pos, input logic [11:0] vel,
			input logic [11:0] tor, input logic [7:0] t_drv, input logic [7:0] t_rot);
		return {t_rot, t_drv, tor[7:0], vel[3:0], tor[11:8], vel[11:4],
			pos[7:0], pos[15:8], st, id};
	endfunction

	task automatic offer_frame(input logic [63:0] bytes, input logic [3:0] len);
		int gap;
		gap = gap_len();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'd0, len, bytes};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic write_limits(input logic [LIM_W-1:0] p, input logic [LIM_W-1:0] v,
			input logic [LIM_W-1:0] t, input logic [LIM_W-1:0] r);
		cfg_we    <= 1'b1;
		cfg_addr  <= REG_POS_LIM;
		cfg_wdata <= p;
		@(negedge clk);
		cfg_addr  <= REG_VEL_LIM;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_addr  <= REG_TOR_LIM;
		cfg_wdata <= t;
		@(negedge clk);
		cfg_addr  <= REG_RED_RECIP;
		cfg_wdata <= r;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Stops offering, waits for every outstanding result and then for the
	// decoder to finish anything that gives no result.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic random_frames(input int n);
		int          sent, r, step, dir;
		logic [15:0] pos;
		logic [3:0]  len;
		logic [63:0] bytes;
		sent = 0;
		dir  = $urandom_range(0, 1) ? 1 : -1;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				len = 4'($urandom_range(0, 7));
			end else if (r < 22) begin
				len = 4'($urandom_range(9, 15));
			end else begin
				len = MIN_FRAME_LEN;
			end
			if ($urandom_range(0, 49) == 0) begin
				dir = -dir;
			end
			r = $urandom_range(0, 99);
			if (r < 65) begin
				step = $urandom_range(0, 6000);
				pos = (dir > 0) ? walk_pos + step[15:0] : walk_pos - step[15:0];
			end else if (r < 80) begin
				pos = walk_pos + 16'd32766 + 16'($urandom_range(0, 3));
			end else begin
				pos = 16'($urandom);
			end
			bytes = {$urandom, $urandom};
			bytes[15:8]  = pos[15:8];
			bytes[23:16] = pos[7:0];
			offer_frame(bytes, len);
			if (len >= MIN_FRAME_LEN) begin
				sent++;
				walk_pos = pos;
			end
		end
	endtask

	initial begin
		int gap;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_req = 1'b0;
				m_tready <= 1'b1;
			end else begin
				gap = gap_len();
				if (gap == 0) begin
					m_tready <= 1'b1;
				end else begin
					m_tready <= 1'b0;
					repeat (gap - 1) @(negedge clk);
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("motor_feedback_frame_decoder_tb: errors");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = REG_POS_LIM;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		quiet     = 1'b0;
		hold_req  = 1'b0;
		walk_pos  = POS_ZERO;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Count extremes, short frames, long lengths and both sides of the
		// half-span turn threshold, on the reset limits.
		offer_frame(frame_bytes(4'h0, 4'h0, 16'd0, 12'd0, 12'd0, 8'h00, 8'h00), 4'd8);
		offer_frame(64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
		offer_frame(64'hFFFF_FFFF_FFFF_FFFF, 4'd7);
		offer_frame(64'h0, 4'd0);
		offer_frame(frame_bytes(4'h5, 4'hA, 16'd32768, 12'd2047, 12'd2048, 8'h01, 8'h80),
			4'd9);
		offer_frame(frame_bytes(4'hA, 4'h5, 16'd65535, 12'd2048, 12'd2047, 8'h80, 8'h01),
			4'd8);
		offer_frame(frame_bytes(4'h3, 4'h1, 16'd32767, 12'd4095, 12'd0, 8'h55, 8'hAA),
			4'd8);
		offer_frame(frame_bytes(4'hC, 4'hE, 16'd0, 12'd0, 12'd4095, 8'hAA, 8'h55), 4'd8);
		offer_frame(frame_bytes(4'hF, 4'h1, 16'd32768, 12'd1, 12'd4094, 8'hFF, 8'h00),
			4'd10);
		offer_frame(frame_bytes(4'h1, 4'hF, 16'd32768, 12'd4094, 12'd1, 8'h00, 8'hFF),
			4'd8);
		offer_frame(64'h5A5A_5A5A_5A5A_5A5A, 4'd8);
		offer_frame(64'hA5A5_A5A5_A5A5_A5A5, 4'd8);
		offer_frame(64'h0123_4567_89AB_CDEF, 4'd3);
		offer_frame(frame_bytes(4'h7, 4'h8, 16'd1, 12'd2048, 12'd2048, 8'd25, 8'd30), 4'd8);
		offer_frame(frame_bytes(4'h8, 4'h7, 16'd65534, 12'd2047, 12'd2047, 8'd90, 8'd120),
			4'd8);
		offer_frame(frame_bytes(4'h2, 4'h3, 16'd32767, 12'd2048, 12'd2048, 8'd0, 8'd0),
			4'd8);
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					write_limits(23'd65536, 23'd65536, 23'd65536, 23'd1);
				end
				1: begin
					write_limits(23'd6553600, 23'd6553600, 23'd6553600, 23'd4194304);
				end
				2: begin
					write_limits(23'd0, 23'd0, 23'd0, 23'd0);
				end
				3: begin
					write_limits(23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF);
				end
				4: begin
					write_limits(POS_LIM_RST, VEL_LIM_RST, TOR_LIM_RST, RED_RECIP_RST);
				end
				default: begin
					write_limits(LIM_W'($urandom_range(65536, 6553600)),
						LIM_W'($urandom_range(65536, 6553600)),
						LIM_W'($urandom_range(65536, 6553600)),
						LIM_W'($urandom_range(1, 4194304)));
				end
			endcase
			quiet = (ph == 3);
			if (ph == 1 || ph == 5) begin
				hold_req = 1'b1;
			end
			random_frames(64);
			settle();
		end

		if (errors == 0 && pending == 0) begin
			$display("motor_feedback_frame_decoder_tb: clean");
		end else begin
			$display("motor_feedback_frame_decoder_tb: errors");
		end
		$finish;
	end

endmodule
